// File: src/mrt_pkg.sv
// Shared types and constants for the masked route table.
package mrt_pkg;

	localparam int ADDR_W = 32;
	localparam int PORT_W = 4;
	localparam int SLOT_W = 4;
	localparam int STAT_W = 2;

	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W = 1;
	localparam int QCNT_W = 2;

	localparam logic REQ_ADD = 1'b0;
	localparam logic REQ_LOOKUP = 1'b1;

	localparam logic [STAT_W-1:0] ST_OK = 2'd0;
	localparam logic [STAT_W-1:0] ST_FULL = 2'd1;
	localparam logic [STAT_W-1:0] ST_NOROUTE = 2'd2;

	typedef struct packed {
		logic              req_type;
		logic [ADDR_W-1:0] address;
		logic [ADDR_W-1:0] mask;
		logic [ADDR_W-1:0] next_hop;
		logic [PORT_W-1:0] port_index;
	} req_t;

	typedef struct packed {
		logic [STAT_W-1:0] status;
		logic [SLOT_W-1:0] slot;
		logic [ADDR_W-1:0] hop_address;
		logic [PORT_W-1:0] out_port;
		logic              on_link;
	} rsp_t;

	typedef struct packed {
		logic              is_add;
		logic [ADDR_W-1:0] address;
		logic [ADDR_W-1:0] mask;
		logic [ADDR_W-1:0] next_hop;
		logic [PORT_W-1:0] port;
	} cmd_t;

endpackage

// File: src/mrt_front.sv
// Request intake: classify each word and hold it in a short command queue.
module mrt_front #(
	parameter int PORT_COUNT = 16
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	output logic          full,
	input  mrt_pkg::req_t req,
	output logic          cmd_valid,
	output mrt_pkg::cmd_t cmd,
	input  logic          cmd_take
);
	import mrt_pkg::*;

	localparam logic [PORT_W-1:0] MAX_PORT = PORT_W'(PORT_COUNT - 1);

	cmd_t              cls;
	cmd_t              queue_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] cnt_q;
	logic              wr_en;
	logic              rd_en;

	always_comb begin
		cls.is_add   = (req.req_type == REQ_ADD);
		cls.address  = req.address;
		cls.mask     = req.mask;
		cls.next_hop = req.next_hop;
		cls.port     = (req.port_index > MAX_PORT) ? MAX_PORT : req.port_index;
	end

	assign full      = (cnt_q == QCNT_W'(QUEUE_DEPTH));
	assign cmd_valid = (cnt_q != '0);
	assign cmd       = queue_q[rd_ptr_q];
	assign wr_en     = push & ~full;
	assign rd_en     = cmd_take & cmd_valid;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			queue_q[wr_ptr_q] <= cls;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (wr_en) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (rd_en) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			priority if (wr_en && !rd_en) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (rd_en && !wr_en) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

// File: src/mrt_back.sv
// Route table execution: add and first-match lookup, with a short result queue.
module mrt_back #(
	parameter int ROUTE_ENTRIES = 16
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          cmd_valid,
	input  mrt_pkg::cmd_t cmd,
	output logic          cmd_take,
	output logic          empty,
	input  logic          pop,
	output mrt_pkg::rsp_t rsp
);
	import mrt_pkg::*;

	localparam int CNT_W = $clog2(ROUTE_ENTRIES + 1);
	localparam int IDX_W = (ROUTE_ENTRIES > 1) ? $clog2(ROUTE_ENTRIES) : 1;

	logic [ADDR_W-1:0] net_q  [ROUTE_ENTRIES];
	logic [ADDR_W-1:0] mask_q [ROUTE_ENTRIES];
	logic [ADDR_W-1:0] hop_q  [ROUTE_ENTRIES];
	logic [PORT_W-1:0] port_q [ROUTE_ENTRIES];
	logic [CNT_W-1:0]  fill_q;

	logic [ROUTE_ENTRIES-1:0] hit;
	logic [ROUTE_ENTRIES-1:0] first;
	logic [ADDR_W-1:0]        sel_hop;
	logic [PORT_W-1:0]        sel_port;
	logic [SLOT_W-1:0]        sel_slot;
	logic                     table_full;
	logic                     do_write;
	rsp_t                     res;

	rsp_t              rq_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] cnt_q;
	logic              rq_full;
	logic              rd_en;

	assign table_full = (fill_q == CNT_W'(ROUTE_ENTRIES));
	assign rq_full    = (cnt_q == QCNT_W'(QUEUE_DEPTH));
	assign cmd_take   = cmd_valid & ~rq_full;
	assign do_write   = cmd_take & cmd.is_add & ~table_full;

	always_comb begin
		for (int i = 0; i < ROUTE_ENTRIES; i++) begin
			hit[i] = (CNT_W'(i) < fill_q) && ((cmd.address & mask_q[i]) == net_q[i]);
		end
		first    = hit & (~hit + 1'b1);
		sel_hop  = '0;
		sel_port = '0;
		sel_slot = '0;
		for (int i = 0; i < ROUTE_ENTRIES; i++) begin
			if (first[i]) begin
				sel_hop  = sel_hop | hop_q[i];
				sel_port = sel_port | port_q[i];
				sel_slot = sel_slot | SLOT_W'(i);
			end
		end
	end

	always_comb begin
		res = '0;
		priority if (cmd.is_add) begin
			if (table_full) begin
				res.status = ST_FULL;
			end else begin
				res.status = ST_OK;
				res.slot   = SLOT_W'(fill_q);
			end
		end else if (|hit) begin
			res.status      = ST_OK;
			res.slot        = sel_slot;
			res.hop_address = sel_hop;
			res.out_port    = sel_port;
			res.on_link     = (sel_hop == '0);
		end else begin
			res.status = ST_NOROUTE;
		end
	end

	always_ff @(posedge clk) begin
		if (do_write) begin
			net_q[fill_q[IDX_W-1:0]]  <= cmd.address;
			mask_q[fill_q[IDX_W-1:0]] <= cmd.mask;
			hop_q[fill_q[IDX_W-1:0]]  <= cmd.next_hop;
			port_q[fill_q[IDX_W-1:0]] <= cmd.port;
		end
		if (cmd_take) begin
			rq_q[wr_ptr_q] <= res;
		end
	end

	assign empty = (cnt_q == '0);
	assign rsp   = rq_q[rd_ptr_q];
	assign rd_en = pop & ~empty;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q   <= '0;
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_write) begin
				fill_q <= fill_q + 1'b1;
			end
			if (cmd_take) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (rd_en) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			priority if (cmd_take && !rd_en) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (rd_en && !cmd_take) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

// File: src/masked_route_table_top.sv
// Top level of the masked route table: intake queue, table engine, checks.
// Path: a request word waits in the intake queue; its result word is registered in the result queue.
// Throughput: one request per cycle while neither queue is full, set by the parallel compare
// of all entries and priority pick in the table engine; two-word queues on either side.
// Reset empties both queues and clears the fill count, so the table holds no route.
module masked_route_table_top #(
	parameter int ROUTE_ENTRIES = 16,
	parameter int PORT_COUNT    = 16
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	output logic          full,
	input  mrt_pkg::req_t req,
	output logic          empty,
	input  logic          pop,
	output mrt_pkg::rsp_t rsp
);
	import mrt_pkg::*;

	logic cmd_valid;
	logic cmd_take;
	cmd_t cmd;

	mrt_front #(
		.PORT_COUNT(PORT_COUNT)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.full     (full),
		.req      (req),
		.cmd_valid(cmd_valid),
		.cmd      (cmd),
		.cmd_take (cmd_take)
	);

	mrt_back #(
		.ROUTE_ENTRIES(ROUTE_ENTRIES)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd_valid(cmd_valid),
		.cmd      (cmd),
		.cmd_take (cmd_take),
		.empty    (empty),
		.pop      (pop),
		.rsp      (rsp)
	);

	a_take_valid: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_take |-> cmd_valid)
		else $error("command taken from an empty queue");

	a_take_result: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_take |=> !empty)
		else $error("executed command left no result word");

	a_on_link_hop: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && rsp.on_link) |-> (rsp.hop_address == '0 && rsp.status == ST_OK))
		else $error("on-link result with a gateway");

	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && rsp.status != ST_OK) |-> (rsp.slot == '0 && rsp.out_port == '0))
		else $error("failed request carries entry fields");

endmodule
